@@ src/rdc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helper functions for the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;

  // quotient bits resolved per divider cycle
  localparam int DIV_STEP = 4;

  localparam int IN_VALUE_W = 32;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE  = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 7'd65;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } rdc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } rdc_out_t;

  typedef struct packed {
    logic load;
    logic div;
    logic store;
    logic read;
    logic emit;
  } rdc_cmd_t;

  typedef struct packed {
    logic div_last;
    logic quo_zero;
    logic store_full;
    logic ptr_zero;
  } rdc_status_t;

  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DEC_BASE) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - DEC_BASE);
    end
    return c;
  endfunction

endpackage

@@ src/radix_digit_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts an unsigned value to ASCII digits in base 2..36, most significant
// digit first, flagging the last character of each run.
// ----------------------------------------------------------------------------
//  channel   handshake          payload
//  -------   ----------------   ------------------------------------
//  input     start, busy        operand.value, operand.radix
//  output    strobe             result.digit_char, result.last
//
//  for each digit of an item the shared divider resolves 4 quotient bits a
//  cycle over the whole value, and the remainder is then stored as the
//  digit. busy drops as the last character is strobed, so the next item
//  can be taken in that cycle.
//  synchronous reset clears the sequencer; the receiver cannot stall.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rdc_pkg::rdc_in_t  operand,
  output logic              strobe,
  output rdc_pkg::rdc_out_t result
);
  import rdc_pkg::*;

  rdc_cmd_t    cmd;
  rdc_status_t status;

  rdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (strobe)
  );

  rdc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .operand (operand),
    .cmd     (cmd),
    .status  (status),
    .result  (result)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after item accepted");

  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("character strobed after last of run");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("digit run broken before last character");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((result.digit_char >= CHAR_ZERO && result.digit_char <= 7'd57) ||
                (result.digit_char >= CHAR_A && result.digit_char <= 7'd90)))
    else $error("digit character out of range");
`endif

endmodule

@@ src/rdc_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: runs the divider once per digit, then reads the digits back
// most significant first and strobes one character per cycle.
// ----------------------------------------------------------------------------
module rdc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  rdc_pkg::rdc_status_t status,
  output rdc_pkg::rdc_cmd_t    cmd,
  output logic                 busy,
  output logic                 strobe
);
  import rdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NEXT,
    ST_RD,
    ST_EMIT
  } state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.load  = start;
      ST_DIV:  cmd.div   = 1'b1;
      ST_NEXT: cmd.store = 1'b1;
      ST_RD:   cmd.read  = 1'b1;
      ST_EMIT: begin
        cmd.emit = 1'b1;
        cmd.read = !status.ptr_zero;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      busy   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= (state == ST_EMIT);
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_DIV;
            busy  <= 1'b1;
          end
        end
        ST_DIV: begin
          if (status.div_last) begin
            state <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          // at least one digit is always taken, so zero gives a single '0'
          if (status.quo_zero || status.store_full) begin
            state <= ST_RD;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_RD: state <= ST_EMIT;
        ST_EMIT: begin
          if (status.ptr_zero) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
      endcase
    end
  end

endmodule

@@ src/rdc_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath
// Restoring divider (DIV_STEP bits per cycle), digit store and character
// output register.
// ----------------------------------------------------------------------------
module rdc_datapath #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rdc_pkg::rdc_in_t     operand,
  input  rdc_pkg::rdc_cmd_t    cmd,
  output rdc_pkg::rdc_status_t status,
  output rdc_pkg::rdc_out_t    result
);
  import rdc_pkg::*;

  localparam int PW     = ((VALUE_WIDTH + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int CHUNKS = PW / DIV_STEP;
  localparam int CW     = $clog2(CHUNKS);
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam int DCW    = $clog2(MAX_DIGITS + 1);
  localparam int XW     = (PW > IN_VALUE_W) ? PW : IN_VALUE_W;

  logic [PW-1:0]      quo;
  logic [RADIX_W-1:0] rem;
  logic [RADIX_W-1:0] base;
  logic [CW-1:0]      chunk;
  logic [DCW-1:0]     count;
  logic [DCW-1:0]     ptr;
  logic [RADIX_W-1:0] rdata;
  logic [RADIX_W-1:0] mem [MAX_DIGITS];

  logic [XW-1:0]      val_x;
  logic [PW-1:0]      val_ext;
  logic [PW-1:0]      q_step;
  logic [RADIX_W-1:0] r_step;
  logic [RADIX_W:0]   trial;
  logic [DCW-1:0]     ptr_m1;

  // keep only the low VALUE_WIDTH bits, zero padded to whole chunks
  always_comb begin
    val_x = XW'(operand.value);
    for (int i = 0; i < PW; i++) begin
      val_ext[i] = (i < VALUE_WIDTH) ? val_x[i] : 1'b0;
    end
  end

  // DIV_STEP restoring steps; dividend shifts out as quotient shifts in
  always_comb begin
    q_step = quo;
    r_step = rem;
    trial  = '0;
    for (int s = 0; s < DIV_STEP; s++) begin
      trial  = {r_step, q_step[PW-1]};
      q_step = {q_step[PW-2:0], 1'b0};
      if (trial >= {1'b0, base}) begin
        r_step    = RADIX_W'(trial - {1'b0, base});
        q_step[0] = 1'b1;
      end else begin
        r_step = trial[RADIX_W-1:0];
      end
    end
  end

  assign ptr_m1 = ptr - DCW'(1);

  assign status.div_last   = (chunk == CW'(CHUNKS - 1));
  assign status.quo_zero   = (quo == '0);
  assign status.store_full = (count == DCW'(MAX_DIGITS - 1));
  assign status.ptr_zero   = (ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk <= '0;
      count <= '0;
      ptr   <= '0;
    end else begin
      if (cmd.load) begin
        chunk <= '0;
        count <= '0;
      end
      if (cmd.div) begin
        chunk <= chunk + CW'(1);
      end
      if (cmd.store) begin
        chunk <= '0;
        count <= count + DCW'(1);
        ptr   <= count + DCW'(1);
      end
      if (cmd.read) begin
        ptr <= ptr_m1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo  <= val_ext;
      rem  <= '0;
      base <= sat_radix(operand.radix);
    end
    if (cmd.div) begin
      quo <= q_step;
      rem <= r_step;
    end
    if (cmd.store) begin
      rem <= '0;
    end
    if (cmd.emit) begin
      result.digit_char <= digit_ascii(rdata);
      result.last       <= (ptr == '0);
    end
  end

  // digit store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[count[AW-1:0]] <= rem;
    end
    if (cmd.read) begin
      rdata <= mem[ptr_m1[AW-1:0]];
    end
  end

endmodule

@@ tb/radix_digit_converter_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter_tb
// Self-checking bench for the radix digit converter. Each accepted item is
// turned into its expected ASCII digit string, most significant digit first,
// and every strobed character is compared against it in order. Stimulus has
// a directed part and then random values and bases with random sender gaps.
// ----------------------------------------------------------------------------
module radix_digit_converter_tb;
  import rdc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 115;

  // expected digit strings, kept as one flat queue of characters
  class char_scoreboard;
    rdc_out_t    pending_chars[$];
    int unsigned errors;
    int unsigned items_seen;
    int unsigned chars_seen;
    int unsigned clamped_radix;

    function void note_item(rdc_in_t it);
      logic [RADIX_W-1:0] base;
      logic [31:0]        rem;
      logic [RADIX_W-1:0] digs[$];
      rdc_out_t           ch;
      base = it.radix;
      if (base < RADIX_MIN) begin
        base = RADIX_MIN;
      end else if (base > RADIX_MAX) begin
        base = RADIX_MAX;
      end
      if (base != it.radix) begin
        clamped_radix++;
      end
      rem = it.value;
      if (rem == 0) begin
        digs.push_back('0);
      end
      // least significant digit first
      while (rem != 0 && digs.size() < MAX_DIGITS_DEF) begin
        digs.push_back(RADIX_W'(rem % 32'(base)));
        rem = rem / 32'(base);
      end
      for (int k = digs.size() - 1; k >= 0; k--) begin
        if (digs[k] < DEC_BASE) begin
          ch.digit_char = CHAR_ZERO + CHAR_W'(digs[k]);
        end else begin
          ch.digit_char = CHAR_A + CHAR_W'(digs[k] - DEC_BASE);
        end
        ch.last = (k == 0);
        pending_chars.push_back(ch);
      end
      items_seen++;
    endfunction

    function void check_char(rdc_out_t got);
      rdc_out_t want;
      chars_seen++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character: digit_char %0d last %0b", got.digit_char, got.last);
        errors++;
        return;
      end
      want = pending_chars.pop_front();
      if (got.digit_char !== want.digit_char) begin
        $error("digit_char: expected %0d, got %0d", want.digit_char, got.digit_char);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  rdc_in_t  operand;
  logic     strobe;
  rdc_out_t result;

  char_scoreboard sb;
  int unsigned    quiet_cycles = 0;

  radix_digit_converter dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .operand (operand),
    .strobe  (strobe),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rdc_in_t make_item(logic [31:0] v, logic [RADIX_W-1:0] r);
    rdc_in_t it;
    it.value = v;
    it.radix = r;
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 95) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic rdc_in_t random_item();
    rdc_in_t            it;
    int unsigned        kind;
    logic [RADIX_W-1:0] b;
    logic [63:0]        p;
    int unsigned        n;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 7) == 0) begin
      it.radix = RADIX_W'($urandom_range(0, 63));
    end else begin
      it.radix = RADIX_W'($urandom_range(2, 36));
    end
    case (kind)
      0, 1, 2, 3: begin
        it.value = $urandom();
      end
      4, 5: begin
        it.value = $urandom_range(0, 1000);
      end
      6: begin
        it.value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
      end
      7: begin
        it.value = 32'd1 << $urandom_range(0, 31);
      end
      8: begin
        // just below or at a power of the base: digit count rolls over here
        b = it.radix;
        if (b < RADIX_MIN) begin
          b = RADIX_MIN;
        end else if (b > RADIX_MAX) begin
          b = RADIX_MAX;
        end
        p = 64'd1;
        n = $urandom_range(1, 32);
        repeat (n) begin
          if (p * 64'(b) <= 64'hFFFF_FFFF) begin
            p = p * 64'(b);
          end
        end
        it.value = 32'(p - 64'($urandom_range(0, 1)));
      end
      default: begin
        it.value = '0;
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input rdc_in_t it, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    operand <= it;
    @(posedge clk);
    while (busy !== 1'b0) begin
      @(posedge clk);
    end
    sb.note_item(it);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending_chars.size() != 0);
  endtask

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe === 1'b1) begin
        sb.check_char(result);
      end
      if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no item or character for %0d cycles", QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    rst     <= 1'b1;
    start   <= 1'b0;
    operand <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: zero value, extremes, clamped radix, letter digits
    send_item(make_item(32'd0, 6'd10), 1);
    send_item(make_item(32'd0, 6'd0), 0);
    send_item(make_item(32'hFFFF_FFFF, RADIX_MIN), 0);
    send_item(make_item(32'hFFFF_FFFF, RADIX_MAX), 2);
    send_item(make_item(32'h8000_0000, RADIX_MIN), 0);
    send_item(make_item(32'd1, RADIX_MAX), 0);
    send_item(make_item(32'd12345, 6'd0), 3);
    send_item(make_item(32'd12345, 6'd1), 0);
    send_item(make_item(32'd35, 6'd37), 0);
    send_item(make_item(32'd36, 6'd63), 1);
    send_item(make_item(32'hDEAD_BEEF, 6'd16), 0);
    send_item(make_item(32'd4294967295, DEC_BASE), 0);
    send_item(make_item(32'd9, DEC_BASE), 5);
    send_item(make_item(32'd10, DEC_BASE), 0);
    send_item(make_item(32'h5555_5555, 6'd4), 0);
    send_item(make_item(32'd1295, RADIX_MAX), 0);
    send_item(make_item(32'hAAAA_AAAA, 6'd42), 2);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        drain_results();
      end
      // every 40 items a burst with no sender gaps
      send_item(random_item(), (i % 40 < 8) ? 0 : pick_gap());
    end
    start <= 1'b0;

    while (sb.pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d items into %0d characters, %0d with a clamped radix",
             sb.items_seen, sb.chars_seen, sb.clamped_radix);
    $display("mismatches found: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rdc_pkg.sv
src/rdc_ctrl.sv
src/rdc_datapath.sv
src/radix_digit_converter.sv
tb/radix_digit_converter_tb.sv
